// ===== design/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Words   = 5;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned BlockW  = 512;
  localparam int unsigned LenW    = 64;
  localparam int unsigned FillW   = 6;
  localparam int unsigned RoundW  = 7;
  localparam int unsigned IdxW    = 3;

  localparam logic [FillW-1:0]  FillLast   = 6'd63;
  localparam logic [FillW-1:0]  FillLength = 6'd56;
  localparam logic [RoundW-1:0] RoundLast  = 7'(Rounds - 1);
  localparam logic [IdxW-1:0]   IdxLast    = 3'(Words - 1);
  localparam logic [7:0]        PadMarker  = 8'h80;
  localparam logic [LenW-1:0]   BitsPerByte = 64'd8;

  localparam logic [Words-1:0][WordW-1:0] ChainInit = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_ONE,
    ST_PAD_ZERO,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } sha1_state_e;

  typedef struct packed {
    logic take_byte;
    logic shift_pad;
    logic pad_one;
    logic load_len;
    logic round_en;
    logic chain_add;
    logic emit_done;
  } sha1_ctrl_t;

  function automatic logic [WordW-1:0] sha1_round_k(input logic [RoundW-1:0] t);
    logic [WordW-1:0] k;
    priority if (t < 7'd20) begin
      k = 32'h5A827999;
    end else if (t < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (t < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic logic [WordW-1:0] sha1_round_f(input logic [RoundW-1:0] t,
                                                   input logic [WordW-1:0] b,
                                                   input logic [WordW-1:0] c,
                                                   input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    priority if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== design/sha1_if.sv =====
`default_nettype none

interface sha1_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

interface sha1_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

// ===== design/sha1_stream_hasher.sv =====
// A request without the end flag takes its byte; the 64th byte of a block starts 80 rounds
// on the single round adder and then one chain update. An end request pads one byte per
// cycle up to byte 56 (pausing to compress a full block), loads the length, runs one or
// two compressions and offers the five digest words, one per cycle while ready is high.
// Reset is asynchronous and active low: it loads the initial chain value and clears the
// counters; the message window holds no defined value until bytes are written.
`default_nettype none

module sha1_stream_hasher (
  input  logic           clk_i,
  input  logic           rst_ni,
  sha1_req_if.sink       req_i,
  sha1_digest_if.source  digest_o
);
  import sha1_pkg::*;

  sha1_state_e state_q, state_d;
  sha1_state_e ret_q, ret_d;
  sha1_ctrl_t  ctrl;

  logic [Words-1:0][WordW-1:0] chain_q;
  logic [Words-1:0][WordW-1:0] work_q;
  logic [BlockW-1:0]           window_q;
  logic [LenW-1:0]             count_q;
  logic [FillW-1:0]            fill_q;
  logic [RoundW-1:0]           round_q;
  logic [IdxW-1:0]             idx_q;

  logic [WordW-1:0] w_t;
  logic [WordW-1:0] w_new;
  logic [WordW-1:0] mix;
  logic [WordW-1:0] temp;
  logic [7:0]       pad_byte;
  logic             req_hs;
  logic             out_hs;

  assign req_hs = req_i.valid && req_i.ready;
  assign out_hs = digest_o.valid && digest_o.ready;

  // The window holds W[t] .. W[t+15], oldest word in the top bits.
  assign w_t   = window_q[511:480];
  assign mix   = window_q[95:64] ^ window_q[255:224] ^ window_q[447:416] ^ w_t;
  assign w_new = {mix[30:0], mix[31]};
  assign temp  = {work_q[0][26:0], work_q[0][31:27]}
               + sha1_round_f(round_q, work_q[1], work_q[2], work_q[3])
               + work_q[4] + sha1_round_k(round_q) + w_t;
  assign pad_byte = ctrl.pad_one ? PadMarker : 8'h00;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (req_i.has_byte && fill_q == FillLast) begin
            state_d = ST_ROUND;
            ret_d   = req_i.end_of_message ? ST_PAD_ONE : ST_IDLE;
          end else if (req_i.end_of_message) begin
            state_d = ST_PAD_ONE;
          end
        end
      end
      ST_PAD_ONE: begin
        if (fill_q == FillLast) begin
          state_d = ST_ROUND;
          ret_d   = ST_PAD_ZERO;
        end else begin
          state_d = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (fill_q == FillLength) begin
          state_d = ST_ROUND;
          ret_d   = ST_EMIT;
        end else if (fill_q == FillLast) begin
          state_d = ST_ROUND;
          ret_d   = ST_PAD_ZERO;
        end
      end
      ST_ROUND: begin
        if (round_q == RoundLast) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        state_d = ret_q;
      end
      ST_EMIT: begin
        if (digest_o.ready && idx_q == IdxLast) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl           = '0;
    req_i.ready    = 1'b0;
    digest_o.valid = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_i.ready    = 1'b1;
        ctrl.take_byte = req_i.valid && req_i.has_byte;
      end
      ST_PAD_ONE: begin
        ctrl.shift_pad = 1'b1;
        ctrl.pad_one   = 1'b1;
      end
      ST_PAD_ZERO: begin
        if (fill_q == FillLength) begin
          ctrl.load_len = 1'b1;
        end else begin
          ctrl.shift_pad = 1'b1;
        end
      end
      ST_ROUND: begin
        ctrl.round_en = 1'b1;
      end
      ST_ADD: begin
        ctrl.chain_add = 1'b1;
      end
      ST_EMIT: begin
        digest_o.valid = 1'b1;
        ctrl.emit_done = digest_o.ready && idx_q == IdxLast;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  assign digest_o.digest_word = chain_q[idx_q];
  assign digest_o.word_index  = idx_q;
  assign digest_o.last_word   = idx_q == IdxLast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      chain_q <= ChainInit;
      count_q <= '0;
      fill_q  <= '0;
      round_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (ctrl.load_len) begin
        fill_q <= '0;
      end else if (ctrl.take_byte || ctrl.shift_pad) begin
        fill_q <= fill_q + 6'd1;
      end
      if (ctrl.emit_done) begin
        count_q <= '0;
      end else if (ctrl.take_byte) begin
        count_q <= count_q + BitsPerByte;
      end
      if (ctrl.round_en) begin
        round_q <= (round_q == RoundLast) ? '0 : round_q + 7'd1;
      end
      if (out_hs) begin
        idx_q <= (idx_q == IdxLast) ? '0 : idx_q + 3'd1;
      end
      if (ctrl.emit_done) begin
        chain_q <= ChainInit;
      end else if (ctrl.chain_add) begin
        for (int i = 0; i < Words; i++) begin
          chain_q[i] <= chain_q[i] + work_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.take_byte) begin
      window_q <= {window_q[503:0], req_i.data_byte};
    end else if (ctrl.shift_pad) begin
      window_q <= {window_q[503:0], pad_byte};
    end else if (ctrl.load_len) begin
      window_q <= {window_q[447:0], count_q};
    end else if (ctrl.round_en) begin
      window_q <= {window_q[479:0], w_new};
    end
    if (state_q != ST_ROUND && state_d == ST_ROUND) begin
      work_q <= chain_q;
    end else if (ctrl.round_en) begin
      work_q <= {work_q[3], work_q[2], {work_q[1][1:0], work_q[1][31:2]}, work_q[0], temp};
    end
  end

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !digest_o.valid)
    else $error("request and digest channels open together");

  a_round_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (round_q != '0) |-> (state_q == ST_ROUND))
    else $error("round counter left nonzero outside compression");

  a_emit_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (fill_q == '0))
    else $error("digest offered with a partial block pending");

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_hs && digest_o.last_word) |=>
      (state_q == ST_IDLE && chain_q[0] == ChainInit[0] && count_q == '0))
    else $error("hasher not re-armed after the last digest word");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_EMIT) |-> (idx_q == '0))
    else $error("word index not at zero outside digest output");

endmodule

`default_nettype wire
